### design/tilt_level_classifier_macros.svh
// Assertion macros of the tilt level classifier, used by its top-level design file.
// Holds no logic; a file that asserts includes it by its bare name.
`ifndef TILT_LEVEL_CLASSIFIER_MACROS_SVH
`define TILT_LEVEL_CLASSIFIER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TLC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tilt_level_classifier: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define TLC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tilt_level_classifier: next-cycle check failed");

`endif

### design/tlc_pkg.sv
// Types and constants of the tilt level classifier.
// Used by tlc_grade and tilt_level_classifier; depends on nothing.
package tlc_pkg;

   localparam int SAMPLE_W  = 14;
   localparam int CORR_W    = 15;
   localparam int CALC_W    = 16;
   localparam int LIMIT_W   = 13;
   localparam int LEVEL_W   = 3;
   localparam int CLASS_W   = 2;
   localparam int DIR_W     = 2;
   localparam int CSR_IDX_W = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_EQUILIBRIUM = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW        = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MEDIUM      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAST        = 2'd3;

   localparam logic [LIMIT_W-1:0] EQUILIBRIUM_RST = 13'd410;
   localparam logic [LIMIT_W-1:0] SLOW_RST        = 13'd2049;
   localparam logic [LIMIT_W-1:0] MEDIUM_RST      = 13'd3277;
   localparam logic [LIMIT_W-1:0] FAST_RST        = 13'd4096;

   localparam logic [CLASS_W-1:0] CLS_NONE  = 2'd0;
   localparam logic [CLASS_W-1:0] CLS_ROLL  = 2'd1;
   localparam logic [CLASS_W-1:0] CLS_PITCH = 2'd2;
   localparam logic [CLASS_W-1:0] CLS_BOTH  = 2'd3;

   localparam logic [LEVEL_W-1:0] LVL_NONE     = 3'd0;
   localparam logic [LEVEL_W-1:0] LVL_SLOW     = 3'd1;
   localparam logic [LEVEL_W-1:0] LVL_MEDIUM   = 3'd2;
   localparam logic [LEVEL_W-1:0] LVL_FAST     = 3'd3;
   localparam logic [LEVEL_W-1:0] LVL_COMBINED = 3'd4;

   localparam logic [DIR_W-1:0] DIR_NONE     = 2'd0;
   localparam logic [DIR_W-1:0] DIR_POSITIVE = 2'd1;
   localparam logic [DIR_W-1:0] DIR_NEGATIVE = 2'd2;

   // Deadband bounds before the first recorded value.
   localparam logic signed [CALC_W-1:0] BAND_MAX = 16'sh7FFF;
   localparam logic signed [CALC_W-1:0] BAND_MIN = 16'sh8000;

   typedef struct packed {
      logic [LIMIT_W-1:0] equilibrium;
      logic [LIMIT_W-1:0] slow;
      logic [LIMIT_W-1:0] mid;
      logic [LIMIT_W-1:0] fast;
   } limits_type;

   typedef struct packed {
      logic               hit;
      logic [LEVEL_W-1:0] level;
      logic [DIR_W-1:0]   dir;
   } grade_type;

endpackage

### design/tilt_level_classifier.sv
// Top level of the tilt level classifier: calibration, deadband and classification.
// Depends on tlc_pkg, tlc_grade and tilt_level_classifier_macros.svh.
//
//  channel   direction  handshake              payload
//  req       in         req_valid / req_ready  req_sample_x, req_sample_y
//  rsp       out        rsp_valid / rsp_ready  rsp_calibrated ... rsp_corrected_y
//  csr       in         csr_valid / csr_ready  csr_index, csr_data
//
// One request is accepted in every cycle while the result side keeps up; the
// result passes through the input register, then the result register. The
// single combinational stage between them holds the offset multiplier, the
// deadband compares and the band search, and all state is updated there.
// Reset is synchronous; no clearing pass is needed. A stall on the result
// side propagates back to req_ready in the same cycle, so no request is ever
// dropped. Configuration writes are taken in every cycle.
module tilt_level_classifier #(
   parameter int AVG_SAMPLES = 128
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [tlc_pkg::SAMPLE_W-1:0]   req_sample_x,
   input  logic signed [tlc_pkg::SAMPLE_W-1:0]   req_sample_y,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_calibrated,
   output logic [tlc_pkg::CLASS_W-1:0]           rsp_movement_class,
   output logic [tlc_pkg::LEVEL_W-1:0]           rsp_roll_level,
   output logic [tlc_pkg::LEVEL_W-1:0]           rsp_pitch_level,
   output logic [tlc_pkg::DIR_W-1:0]             rsp_tilt_direction,
   output logic signed [tlc_pkg::CORR_W-1:0]     rsp_corrected_x,
   output logic signed [tlc_pkg::CORR_W-1:0]     rsp_corrected_y,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [tlc_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [tlc_pkg::LIMIT_W-1:0]           csr_data
);
   import tlc_pkg::*;

`include "tilt_level_classifier_macros.svh"

   // The sums hold each sample plus half the sample range, so they are never
   // negative. The offset is then floor(sum / AVG_SAMPLES) minus that bias,
   // found by one multiplication with a rounded-up reciprocal, which is exact
   // for every sum below 2**SUM_W.
   localparam int LOG_N   = $clog2(AVG_SAMPLES);
   localparam int SUM_W   = SAMPLE_W + LOG_N;
   localparam int SHIFT   = SUM_W + LOG_N;
   localparam int RECIP_W = SUM_W + 1;
   localparam int PROD_W  = SUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));
   localparam int CNT_W = $clog2(2 * AVG_SAMPLES + 1);
   localparam logic [CNT_W-1:0] CNT_OFFSET = CNT_W'(AVG_SAMPLES);
   localparam logic [CNT_W-1:0] CNT_END    = CNT_W'(2 * AVG_SAMPLES);

   // Configuration registers.
   limits_type limits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{equilibrium: EQUILIBRIUM_RST, slow: SLOW_RST,
                        mid: MEDIUM_RST, fast: FAST_RST};
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_EQUILIBRIUM: limits_ff.equilibrium <= csr_data;
            CSR_SLOW:        limits_ff.slow        <= csr_data;
            CSR_MEDIUM:      limits_ff.mid         <= csr_data;
            CSR_FAST:        limits_ff.fast        <= csr_data;
         endcase
      end
   end

   assign csr_ready = 1'b1;

   // Handshake: the input register moves on whenever the result register is
   // free or is being emptied in this cycle.
   logic                       in_valid_ff;
   logic signed [SAMPLE_W-1:0] in_x_ff, in_y_ff;
   logic                       rsp_valid_ff;
   logic                       out_free, step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_free) begin
            rsp_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_x_ff <= req_sample_x;
         in_y_ff <= req_sample_y;
      end
   end

   // Calibration state.
   logic [CNT_W-1:0]           cnt_ff;
   logic [SUM_W-1:0]           sum_x_ff, sum_y_ff;
   logic signed [SAMPLE_W-1:0] offset_x_ff, offset_y_ff;
   logic signed [CALC_W-1:0]   band_low_x_ff, band_high_x_ff;
   logic signed [CALC_W-1:0]   band_low_y_ff, band_high_y_ff;
   logic                       cal_done, cal_sum, cal_offset;

   assign cal_done   = (cnt_ff == CNT_END);
   assign cal_sum    = (cnt_ff < CNT_OFFSET);
   assign cal_offset = (cnt_ff == CNT_OFFSET);

   // Biased samples: adding half the range flips the sign bit.
   logic [SAMPLE_W-1:0] biased_x, biased_y;
   assign biased_x = {~in_x_ff[SAMPLE_W-1], in_x_ff[SAMPLE_W-2:0]};
   assign biased_y = {~in_y_ff[SAMPLE_W-1], in_y_ff[SAMPLE_W-2:0]};

   logic [PROD_W-1:0]   prod_x, prod_y;
   logic [SAMPLE_W-1:0] quot_x, quot_y;
   assign prod_x = PROD_W'(sum_x_ff) * PROD_W'(RECIP);
   assign prod_y = PROD_W'(sum_y_ff) * PROD_W'(RECIP);
   assign quot_x = prod_x[SHIFT +: SAMPLE_W];
   assign quot_y = prod_y[SHIFT +: SAMPLE_W];

   // Offset-corrected samples, and the same after the deadband.
   logic signed [CALC_W-1:0] diff_x, diff_y, x_val, y_val;
   assign diff_x = CALC_W'(in_x_ff) - CALC_W'(offset_x_ff);
   assign diff_y = CALC_W'(in_y_ff) - CALC_W'(offset_y_ff);
   assign x_val  = (diff_x < band_high_x_ff && diff_x > band_low_x_ff) ? '0 : diff_x;
   assign y_val  = (diff_y < band_high_y_ff && diff_y > band_low_y_ff) ? '0 : diff_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         sum_x_ff       <= '0;
         sum_y_ff       <= '0;
         offset_x_ff    <= '0;
         offset_y_ff    <= '0;
         band_low_x_ff  <= BAND_MAX;
         band_high_x_ff <= BAND_MIN;
         band_low_y_ff  <= BAND_MAX;
         band_high_y_ff <= BAND_MIN;
      end else if (step && !cal_done) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
         if (cal_sum) begin
            sum_x_ff <= sum_x_ff + SUM_W'(biased_x);
            sum_y_ff <= sum_y_ff + SUM_W'(biased_y);
         end else if (cal_offset) begin
            // Removing the bias flips the sign bit back.
            offset_x_ff <= signed'({~quot_x[SAMPLE_W-1], quot_x[SAMPLE_W-2:0]});
            offset_y_ff <= signed'({~quot_y[SAMPLE_W-1], quot_y[SAMPLE_W-2:0]});
         end else begin
            if (diff_x > band_high_x_ff) band_high_x_ff <= diff_x;
            if (diff_x < band_low_x_ff)  band_low_x_ff  <= diff_x;
            if (diff_y > band_high_y_ff) band_high_y_ff <= diff_y;
            if (diff_y < band_low_y_ff)  band_low_y_ff  <= diff_y;
         end
      end
   end

   // Classification. An axis exactly on the equilibrium limit is neither
   // inside nor outside, and then the previous class is kept.
   logic signed [CALC_W-1:0] eq_pos, eq_neg;
   logic                     in_x, in_y, out_x, out_y;
   logic [CLASS_W-1:0]       class_ff, class_in;
   logic [LEVEL_W-1:0]       roll_ff, roll_in, pitch_ff, pitch_in;
   logic [DIR_W-1:0]         dir_ff, dir_in;
   grade_type                grade_x, grade_y;

   assign eq_pos = signed'({{(CALC_W-LIMIT_W){1'b0}}, limits_ff.equilibrium});
   assign eq_neg = -eq_pos;
   assign in_x   = (x_val < eq_pos) && (x_val > eq_neg);
   assign in_y   = (y_val < eq_pos) && (y_val > eq_neg);
   assign out_x  = (x_val > eq_pos) || (x_val < eq_neg);
   assign out_y  = (y_val > eq_pos) || (y_val < eq_neg);

   tlc_grade u_grade_x (
      .value  (x_val),
      .limits (limits_ff),
      .result (grade_x)
   );

   tlc_grade u_grade_y (
      .value  (y_val),
      .limits (limits_ff),
      .result (grade_y)
   );

   always_comb begin
      if (in_x && in_y)        class_in = CLS_NONE;
      else if (out_x && in_y)  class_in = CLS_ROLL;
      else if (out_y && in_x)  class_in = CLS_PITCH;
      else if (out_x && out_y) class_in = CLS_BOTH;
      else                     class_in = class_ff;

      // Level and direction hold when the selected axis falls in no band.
      roll_in  = LVL_NONE;
      pitch_in = LVL_NONE;
      dir_in   = dir_ff;
      case (class_in)
         CLS_ROLL: begin
            roll_in = grade_x.hit ? grade_x.level : roll_ff;
            if (grade_x.hit) dir_in = grade_x.dir;
         end
         CLS_PITCH: begin
            pitch_in = grade_y.hit ? grade_y.level : pitch_ff;
            if (grade_y.hit) dir_in = grade_y.dir;
         end
         CLS_BOTH: begin
            roll_in  = LVL_COMBINED;
            pitch_in = LVL_COMBINED;
         end
         default: begin
            roll_in  = LVL_NONE;
            pitch_in = LVL_NONE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         class_ff <= CLS_NONE;
         roll_ff  <= LVL_NONE;
         pitch_ff <= LVL_NONE;
         dir_ff   <= DIR_NONE;
      end else if (step && cal_done) begin
         class_ff <= class_in;
         roll_ff  <= roll_in;
         pitch_ff <= pitch_in;
         dir_ff   <= dir_in;
      end
   end

   // Result register; every field reads zero while calibration runs.
   logic                     rsp_calibrated_ff;
   logic [CLASS_W-1:0]       rsp_class_ff;
   logic [LEVEL_W-1:0]       rsp_roll_ff, rsp_pitch_ff;
   logic [DIR_W-1:0]         rsp_dir_ff;
   logic signed [CORR_W-1:0] rsp_x_ff, rsp_y_ff;

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_calibrated_ff <= cal_done;
         rsp_class_ff      <= cal_done ? class_in : CLS_NONE;
         rsp_roll_ff       <= cal_done ? roll_in  : LVL_NONE;
         rsp_pitch_ff      <= cal_done ? pitch_in : LVL_NONE;
         rsp_dir_ff        <= cal_done ? dir_in   : DIR_NONE;
         rsp_x_ff          <= cal_done ? x_val[CORR_W-1:0] : '0;
         rsp_y_ff          <= cal_done ? y_val[CORR_W-1:0] : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_calibrated     = rsp_calibrated_ff;
   assign rsp_movement_class = rsp_class_ff;
   assign rsp_roll_level     = rsp_roll_ff;
   assign rsp_pitch_level    = rsp_pitch_ff;
   assign rsp_tilt_direction = rsp_dir_ff;
   assign rsp_corrected_x    = rsp_x_ff;
   assign rsp_corrected_y    = rsp_y_ff;

   // Results delivered during calibration carry nothing but zeros.
   `TLC_ASSERT_SAME(a_uncal_zero, clock, reset, rsp_valid_ff && !rsp_calibrated_ff, rsp_class_ff == CLS_NONE && rsp_roll_ff == LVL_NONE && rsp_pitch_ff == LVL_NONE && rsp_dir_ff == DIR_NONE && rsp_x_ff == '0 && rsp_y_ff == '0)
   // A combined movement sets both levels to the combined code.
   `TLC_ASSERT_SAME(a_both_levels, clock, reset, rsp_valid_ff && rsp_class_ff == CLS_BOTH, rsp_roll_ff == LVL_COMBINED && rsp_pitch_ff == LVL_COMBINED)
   // A pure roll never reports a pitch level.
   `TLC_ASSERT_SAME(a_roll_only, clock, reset, rsp_valid_ff && rsp_class_ff == CLS_ROLL, rsp_pitch_ff == LVL_NONE)
   // Once calibration has finished it stays finished.
   `TLC_ASSERT_NEXT(a_cal_sticky, clock, reset, cal_done, cal_done)
   // The sample counter stops at the end of calibration.
   `TLC_ASSERT_SAME(a_cnt_bound, clock, reset, 1'b1, cnt_ff <= CNT_END)

endmodule

### design/tlc_grade.sv
// Band search for one axis: finds the tilt level and direction of a value.
// Depends on tlc_pkg.
module tlc_grade (
   input  logic signed [tlc_pkg::CALC_W-1:0] value,
   input  tlc_pkg::limits_type               limits,
   output tlc_pkg::grade_type                result
);
   import tlc_pkg::*;

   logic signed [CALC_W-1:0] e_pos, s_pos, m_pos, f_pos;
   logic signed [CALC_W-1:0] e_neg, s_neg, m_neg, f_neg;

   assign e_pos = signed'({{(CALC_W-LIMIT_W){1'b0}}, limits.equilibrium});
   assign s_pos = signed'({{(CALC_W-LIMIT_W){1'b0}}, limits.slow});
   assign m_pos = signed'({{(CALC_W-LIMIT_W){1'b0}}, limits.mid});
   assign f_pos = signed'({{(CALC_W-LIMIT_W){1'b0}}, limits.fast});
   assign e_neg = -e_pos;
   assign s_neg = -s_pos;
   assign m_neg = -m_pos;
   assign f_neg = -f_pos;

   // Later bands override earlier ones, and within a band the negative
   // test overrides the positive one, so the search runs from the last test.
   always_comb begin
      result = '{hit: 1'b1, level: LVL_NONE, dir: DIR_NONE};
      if (value <= m_neg && value >= f_neg) begin
         result.level = LVL_FAST;
         result.dir   = DIR_NEGATIVE;
      end else if (value >= m_pos && value <= f_pos) begin
         result.level = LVL_FAST;
         result.dir   = DIR_POSITIVE;
      end else if (value <= s_neg && value >= m_neg) begin
         result.level = LVL_MEDIUM;
         result.dir   = DIR_NEGATIVE;
      end else if (value >= s_pos && value <= m_pos) begin
         result.level = LVL_MEDIUM;
         result.dir   = DIR_POSITIVE;
      end else if (value <= e_neg && value >= s_neg) begin
         result.level = LVL_SLOW;
         result.dir   = DIR_NEGATIVE;
      end else if (value >= e_pos && value <= s_pos) begin
         result.level = LVL_SLOW;
         result.dir   = DIR_POSITIVE;
      end else begin
         result.hit = 1'b0;
      end
   end

endmodule
